/* src/pmd_pkg.sv */
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared widths, codes and types of the command-buffer method decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int WordW    = 32;
  localparam int AddrW    = 14;
  localparam int HdrAddrW = 12;
  localparam int CountW   = 13;
  localparam int SubW     = 3;
  localparam int OpW      = 3;
  localparam int HostLimW = 12;
  localparam int EngLimW  = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam int SubLsb   = 13;
  localparam int CountLsb = 16;
  localparam int OpLsb    = 29;

  localparam logic [HostLimW-1:0] HostLimitReset   = 12'd64;
  localparam logic [EngLimW-1:0]  EngineLimitReset = 13'd3584;

  typedef enum logic [OpW-1:0] {
    OP_INC    = 3'd1,
    OP_NONINC = 3'd3,
    OP_IMM    = 3'd4,
    OP_ONEINC = 3'd5,
    OP_END    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    MODE_INC    = 2'd0,
    MODE_NONINC = 2'd1,
    MODE_ONEINC = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TGT_HOST   = 2'd0,
    TGT_ENGINE = 2'd1,
    TGT_MACRO  = 2'd2
  } target_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOST_LIMIT   = 2'd0,
    REG_ENGINE_LIMIT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] arg;
    logic [SubW-1:0]  sub;
    logic             last;
    logic             fault;
  } call_t;

endpackage

/* src/pmd_if.sv */
// ----------------------------------------------------------------------------
// pmd_if
// Handshake channels of the method decoder: command words, method calls and
// register writes.
// ----------------------------------------------------------------------------
interface pmd_word_if;
  logic                       valid;
  logic                       ready;
  logic [pmd_pkg::WordW-1:0]  word;
  logic                       segment_last;

  modport source (output valid, word, segment_last, input ready);
  modport sink   (input valid, word, segment_last, output ready);
endinterface

interface pmd_call_if;
  logic                       valid;
  logic                       ready;
  logic [pmd_pkg::AddrW-1:0]  method_address;
  logic [pmd_pkg::WordW-1:0]  argument;
  logic [pmd_pkg::SubW-1:0]   subchannel;
  logic                       last_of_burst;
  logic [1:0]                 target_class;
  logic [pmd_pkg::AddrW-1:0]  macro_offset;
  logic                       fault;

  modport source (output valid, method_address, argument, subchannel, last_of_burst,
                  target_class, macro_offset, fault, input ready);
  modport sink   (input valid, method_address, argument, subchannel, last_of_burst,
                  target_class, macro_offset, fault, output ready);
endinterface

interface pmd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pmd_pkg::CfgIdxW-1:0]   index;
  logic [pmd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/pmd_decode.sv */
// ----------------------------------------------------------------------------
// pmd_decode
// Header decode and burst state: turns one command word into at most one
// method call and updates the burst, skip and fault state.
// ----------------------------------------------------------------------------
module pmd_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [pmd_pkg::WordW-1:0]  word_i,
  input  logic                       seg_last_i,
  output logic                       emit_o,
  output pmd_pkg::call_t             call_o
);
  import pmd_pkg::*;

  logic [CountW-1:0] wr_q, wr_d;
  logic [AddrW-1:0]  baddr_q, baddr_d;
  logic [SubW-1:0]   bsub_q, bsub_d;
  mode_e             mode_q, mode_d;
  logic              skip_q, skip_d;
  logic              faulted_q, faulted_d;

  logic [OpW-1:0]    op;
  logic [CountW-1:0] count;
  logic [AddrW-1:0]  hdr_addr;
  logic [SubW-1:0]   hdr_sub;

  assign op       = word_i[OpLsb +: OpW];
  assign count    = word_i[CountLsb +: CountW];
  assign hdr_addr = AddrW'(word_i[HdrAddrW-1:0]);
  assign hdr_sub  = word_i[SubLsb +: SubW];

  always_comb begin
    wr_d      = wr_q;
    baddr_d   = baddr_q;
    bsub_d    = bsub_q;
    mode_d    = mode_q;
    skip_d    = skip_q;
    faulted_d = faulted_q;
    emit_o    = 1'b0;
    call_o    = '0;
    if (step_i && !faulted_q) begin
      if (skip_q) begin
        if (seg_last_i) begin
          skip_d = 1'b0;
        end
      end else if (wr_q != '0) begin
        wr_d        = wr_q - 1'b1;
        emit_o      = 1'b1;
        call_o.addr = baddr_q;
        call_o.arg  = word_i;
        call_o.sub  = bsub_q;
        call_o.last = (wr_d == '0);
        case (mode_q)
          MODE_INC: begin
            baddr_d = baddr_q + 1'b1;
          end
          MODE_ONEINC: begin
            baddr_d = baddr_q + 1'b1;
            mode_d  = MODE_NONINC;
          end
          default: ;
        endcase
      end else if (word_i != '0) begin
        case (op)
          OP_INC, OP_NONINC, OP_ONEINC: begin
            wr_d    = count;
            baddr_d = hdr_addr;
            bsub_d  = hdr_sub;
            mode_d  = (op == OP_INC) ? MODE_INC :
                      (op == OP_NONINC) ? MODE_NONINC : MODE_ONEINC;
          end
          OP_IMM: begin
            emit_o      = 1'b1;
            call_o.addr = hdr_addr;
            call_o.arg  = WordW'(count);
            call_o.sub  = hdr_sub;
            call_o.last = 1'b1;
          end
          OP_END: begin
            if (!seg_last_i) begin
              skip_d = 1'b1;
            end
          end
          default: begin
            faulted_d    = 1'b1;
            emit_o       = 1'b1;
            call_o.fault = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      baddr_q   <= '0;
      bsub_q    <= '0;
      mode_q    <= MODE_INC;
      skip_q    <= 1'b0;
      faulted_q <= 1'b0;
    end else begin
      wr_q      <= wr_d;
      baddr_q   <= baddr_d;
      bsub_q    <= bsub_d;
      mode_q    <= mode_d;
      skip_q    <= skip_d;
      faulted_q <= faulted_d;
    end
  end

  a_no_call_after_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    faulted_q |-> !emit_o)
    else $error("call issued after fault");

  a_burst_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !faulted_q && !skip_q && wr_q != '0) |=> (wr_q == $past(wr_q) - 1'b1))
    else $error("burst count did not step down");

  a_fault_item_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && call_o.fault) |-> (call_o.addr == '0 && call_o.arg == '0 && !call_o.last))
    else $error("fault item carries call data");

endmodule

/* src/pmd_route.sv */
// ----------------------------------------------------------------------------
// pmd_route
// Routing class of a method address against the host and engine limits,
// with the macro offset for macro calls.
// ----------------------------------------------------------------------------
module pmd_route (
  input  logic [pmd_pkg::AddrW-1:0]     addr_i,
  input  logic [pmd_pkg::HostLimW-1:0]  host_limit_i,
  input  logic [pmd_pkg::EngLimW-1:0]   engine_limit_i,
  output pmd_pkg::target_e              target_o,
  output logic [pmd_pkg::AddrW-1:0]     offset_o
);
  import pmd_pkg::*;

  logic [AddrW-1:0] host_ext;
  logic [AddrW-1:0] eng_ext;

  assign host_ext = AddrW'(host_limit_i);
  assign eng_ext  = AddrW'(engine_limit_i);

  always_comb begin
    offset_o = '0;
    if (addr_i < host_ext) begin
      target_o = TGT_HOST;
    end else if (addr_i < eng_ext) begin
      target_o = TGT_ENGINE;
    end else begin
      target_o = TGT_MACRO;
      offset_o = addr_i - eng_ext;
    end
  end

endmodule

/* src/pushbuffer_method_decoder.sv */
// ----------------------------------------------------------------------------
// pushbuffer_method_decoder
// Command-buffer method decoder top level: input register, decode and
// routing, result register, limit registers.
// ----------------------------------------------------------------------------
// Takes one command word per clock and gives at most one method call per
// word. A word is captured in the input register, then decoded and routed
// and written to the result register, from which its call is offered.
// Input and result registers form a two-stage pipeline: a word is taken
// every cycle unless a call stalls in the result register and the input
// register is full. Burst and end headers, zero words outside a burst,
// skipped words and words after a fault give no call. The limit registers
// take writes at any time and are meant to be changed while the pipeline is
// empty.
module pushbuffer_method_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmd_word_if.sink   cmd_i,
  pmd_cfg_if.sink    cfg_i,
  pmd_call_if.source call_o
);
  import pmd_pkg::*;

  logic                in_valid_q;
  logic [WordW-1:0]    word_q;
  logic                seg_last_q;
  logic [HostLimW-1:0] host_lim_q;
  logic [EngLimW-1:0]  eng_lim_q;

  logic                out_valid_q;
  call_t               call_q;
  target_e             target_q;
  logic [AddrW-1:0]    offset_q;

  logic                adv;
  logic                step;
  logic                emit;
  call_t               call;
  target_e             target;
  logic [AddrW-1:0]    offset;

  assign adv         = !out_valid_q || call_o.ready;
  assign cmd_i.ready = !in_valid_q || adv;
  assign step        = in_valid_q && adv;
  assign cfg_i.ready = 1'b1;

  pmd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .word_i     (word_q),
    .seg_last_i (seg_last_q),
    .emit_o     (emit),
    .call_o     (call)
  );

  pmd_route u_route (
    .addr_i         (call.addr),
    .host_limit_i   (host_lim_q),
    .engine_limit_i (eng_lim_q),
    .target_o       (target),
    .offset_o       (offset)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      host_lim_q  <= HostLimitReset;
      eng_lim_q   <= EngineLimitReset;
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (adv) begin
        out_valid_q <= step && emit;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_HOST_LIMIT:   host_lim_q <= cfg_i.data[HostLimW-1:0];
          REG_ENGINE_LIMIT: eng_lim_q  <= cfg_i.data[EngLimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      word_q     <= cmd_i.word;
      seg_last_q <= cmd_i.segment_last;
    end
    if (step && emit) begin
      call_q   <= call;
      target_q <= call.fault ? TGT_HOST : target;
      offset_q <= call.fault ? '0 : offset;
    end
  end

  assign call_o.valid          = out_valid_q;
  assign call_o.method_address = call_q.addr;
  assign call_o.argument       = call_q.arg;
  assign call_o.subchannel     = call_q.sub;
  assign call_o.last_of_burst  = call_q.last;
  assign call_o.target_class   = target_q;
  assign call_o.macro_offset   = offset_q;
  assign call_o.fault          = call_q.fault;

endmodule

/* tb/pushbuffer_method_decoder_tb.sv */
// ----------------------------------------------------------------------------
// pushbuffer_method_decoder_tb
// Self-checking bench for the command-buffer method decoder. A queue-fed
// driver streams command words with random gaps, and a monitor checks every
// method call against a cycle-free decoder kept inside the bench. Directed
// headers come first, then random burst, immediate and end-of-segment
// traffic under several limit settings. The run closes with an unsupported
// opcode and the words it must swallow.
// ----------------------------------------------------------------------------
module pushbuffer_method_decoder_tb;
  import pmd_pkg::*;

  localparam int unsigned TimeoutCycles = 400000;
  localparam int          PhaseItems    = 250;
  localparam int          DrainCycles   = 6;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  localparam logic [OpW-1:0] OP_RSVD0 = 3'd0;
  localparam logic [OpW-1:0] OP_RSVD2 = 3'd2;
  localparam logic [OpW-1:0] OP_RSVD6 = 3'd6;

  typedef struct {
    logic [WordW-1:0] word;
    logic             last;
  } cmd_word_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] arg;
    logic [SubW-1:0]  sub;
    logic             last;
    target_e          cls;
    logic [AddrW-1:0] off;
    logic             fault;
  } method_call_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  pmd_word_if word_ch ();
  pmd_cfg_if  cfg_ch ();
  pmd_call_if call_ch ();

  logic                word_valid = 1'b0;
  logic [WordW-1:0]    word_data  = '0;
  logic                word_last  = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                call_ready = 1'b0;

  assign word_ch.valid        = word_valid;
  assign word_ch.word         = word_data;
  assign word_ch.segment_last = word_last;
  assign cfg_ch.valid         = cfg_valid;
  assign cfg_ch.index         = cfg_index;
  assign cfg_ch.data          = cfg_data;
  assign call_ch.ready        = call_ready;

  pushbuffer_method_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (word_ch),
    .cfg_i  (cfg_ch),
    .call_o (call_ch)
  );

  // decoder state and limit registers as seen by the bench
  logic [HostLimW-1:0] host_limit   = HostLimitReset;
  logic [EngLimW-1:0]  engine_limit = EngineLimitReset;
  logic [CountW-1:0]   burst_left   = '0;
  logic [AddrW-1:0]    burst_addr   = '0;
  logic [SubW-1:0]     burst_sub    = '0;
  mode_e               burst_mode   = MODE_INC;
  bit                  skipping     = 1'b0;
  bit                  faulted      = 1'b0;

  cmd_word_t    pending_words[$];
  method_call_t expected_calls[$];
  int           words_queued = 0;
  int           words_taken  = 0;
  int           mismatches   = 0;
  logic         word_taken   = 1'b0;
  int           word_gap     = 0;
  int           word_quiet   = 0;
  int           ready_gap    = 0;
  int           ready_quiet  = 0;
  int           gen_host     = int'(HostLimitReset);
  int           gen_engine   = int'(EngineLimitReset);

  function automatic method_call_t route_call(input logic [AddrW-1:0] addr,
                                              input logic [WordW-1:0] arg,
                                              input logic [SubW-1:0] sub,
                                              input logic last);
    method_call_t c;
    c = '0;
    c.addr = addr;
    c.arg  = arg;
    c.sub  = sub;
    c.last = last;
    if (addr < {2'b00, host_limit}) begin
      c.cls = TGT_HOST;
    end else if (addr < {1'b0, engine_limit}) begin
      c.cls = TGT_ENGINE;
    end else begin
      c.cls = TGT_MACRO;
      c.off = addr - {1'b0, engine_limit};
    end
    return c;
  endfunction

  function automatic bit decode_word(input logic [WordW-1:0] w, input logic seg_last,
                                     output method_call_t c);
    logic [OpW-1:0] op;
    c = '0;
    if (faulted) return 1'b0;
    if (skipping) begin
      if (seg_last) skipping = 1'b0;
      return 1'b0;
    end
    if (burst_left != 0) begin
      burst_left = burst_left - 1'b1;
      c = route_call(burst_addr, w, burst_sub, burst_left == 0);
      if (burst_mode == MODE_INC) begin
        burst_addr = burst_addr + 1'b1;
      end else if (burst_mode == MODE_ONEINC) begin
        burst_addr = burst_addr + 1'b1;
        burst_mode = MODE_NONINC;
      end
      return 1'b1;
    end
    if (w == '0) return 1'b0;
    op = w[OpLsb +: OpW];
    case (op)
      OP_INC, OP_NONINC, OP_ONEINC: begin
        burst_left = w[CountLsb +: CountW];
        burst_addr = {2'b00, w[HdrAddrW-1:0]};
        burst_sub  = w[SubLsb +: SubW];
        if (op == OP_INC) begin
          burst_mode = MODE_INC;
        end else if (op == OP_NONINC) begin
          burst_mode = MODE_NONINC;
        end else begin
          burst_mode = MODE_ONEINC;
        end
        return 1'b0;
      end
      OP_IMM: begin
        c = route_call({2'b00, w[HdrAddrW-1:0]}, {19'b0, w[CountLsb +: CountW]},
                       w[SubLsb +: SubW], 1'b1);
        return 1'b1;
      end
      OP_END: begin
        if (!seg_last) skipping = 1'b1;
        return 1'b0;
      end
      default: begin
        faulted = 1'b1;
        c.fault = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int next_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 120);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WordW-1:0] header(input logic [OpW-1:0] op,
                                              input logic [HdrAddrW-1:0] addr,
                                              input logic [SubW-1:0] sub,
                                              input logic [CountW-1:0] cnt);
    logic spare;
    spare = 1'($urandom_range(0, 1));
    return {op, cnt, sub, spare, addr};
  endfunction

  function automatic logic [HdrAddrW-1:0] pick_addr();
    int r;
    int base;
    int a;
    r = $urandom_range(0, 9);
    if (r < 3) return HdrAddrW'($urandom_range(0, 4095));
    case (r)
      3, 4:    base = gen_host;
      5, 6, 7: base = gen_engine;
      8:       base = 0;
      default: base = 4095;
    endcase
    a = base - 6 + int'($urandom_range(0, 9));
    if (a < 0) a = 0;
    if (a > 4095) a = 4095;
    return HdrAddrW'(a);
  endfunction

  function automatic logic [WordW-1:0] rand_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic rand_last();
    return $urandom_range(0, 5) == 0;
  endfunction

  function automatic void queue_word(input logic [WordW-1:0] w, input logic last);
    cmd_word_t it;
    it.word = w;
    it.last = last;
    pending_words.push_back(it);
    words_queued++;
  endfunction

  // word driver
  always @(negedge clk_i) begin
    cmd_word_t it;
    if (rst_ni) begin
      if (!word_valid || word_taken) begin
        if (word_gap > 0) begin
          word_valid <= 1'b0;
          word_gap = word_gap - 1;
        end else if (pending_words.size() > 0) begin
          it = pending_words.pop_front();
          word_valid <= 1'b1;
          word_data  <= it.word;
          word_last  <= it.last;
          word_gap = next_gap(word_quiet);
        end else begin
          word_valid <= 1'b0;
        end
      end
    end
  end

  // call backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_gap > 0) begin
        call_ready <= 1'b0;
        ready_gap = ready_gap - 1;
      end else begin
        call_ready <= 1'b1;
        ready_gap = next_gap(ready_quiet);
      end
    end
  end

  // prediction on accepted words, checking of accepted calls
  always @(posedge clk_i) begin
    method_call_t predicted;
    method_call_t seen;
    if (rst_ni) begin
      word_taken <= word_valid && word_ch.ready;
      if (cfg_valid && cfg_ch.ready) begin
        case (cfg_index)
          REG_HOST_LIMIT:   host_limit = cfg_data[HostLimW-1:0];
          REG_ENGINE_LIMIT: engine_limit = cfg_data[EngLimW-1:0];
          default: ;
        endcase
      end
      if (word_valid && word_ch.ready) begin
        words_taken++;
        if (decode_word(word_data, word_last, predicted)) expected_calls.push_back(predicted);
      end
      if (call_ch.valid && call_ready) begin
        seen.addr  = call_ch.method_address;
        seen.arg   = call_ch.argument;
        seen.sub   = call_ch.subchannel;
        seen.last  = call_ch.last_of_burst;
        seen.cls   = target_e'(call_ch.target_class);
        seen.off   = call_ch.macro_offset;
        seen.fault = call_ch.fault;
        if (expected_calls.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected call: addr=%0d arg=%h sub=%0d fault=%0d",
                     seen.addr, seen.arg, seen.sub, seen.fault);
        end else begin
          predicted = expected_calls.pop_front();
          if (seen !== predicted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("call mismatch exp: addr=%0d arg=%h sub=%0d last=%0d cls=%0d off=%0d f=%0d",
                       predicted.addr, predicted.arg, predicted.sub, predicted.last,
                       predicted.cls, predicted.off, predicted.fault);
              $display("              got: addr=%0d arg=%h sub=%0d last=%0d cls=%0d off=%0d f=%0d",
                       seen.addr, seen.arg, seen.sub, seen.last, seen.cls, seen.off, seen.fault);
            end
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained(input int settle);
    do @(negedge clk_i); while (words_taken != words_queued || expected_calls.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic play_traffic(input int n);
    int made;
    int kind;
    int cnt;
    int k;
    logic [OpW-1:0] op;
    logic sl;
    made = 0;
    @(posedge clk_i);
    while (made < n) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0:       op = OP_INC;
        1:       op = OP_NONINC;
        default: op = OP_ONEINC;
      endcase
      if (kind < 60) begin
        k = $urandom_range(0, 99);
        if (k < 70) cnt = $urandom_range(0, 8);
        else if (k < 95) cnt = $urandom_range(9, 64);
        else cnt = $urandom_range(65, 300);
        queue_word(header(op, pick_addr(), SubW'($urandom_range(0, 7)), CountW'(cnt)),
                   rand_last());
        repeat (cnt) queue_word(rand_data(), rand_last());
        made += cnt + 1;
      end else if (kind < 78) begin
        queue_word(header(OP_IMM, pick_addr(), SubW'($urandom_range(0, 7)),
                          CountW'($urandom)), rand_last());
        made++;
      end else if (kind < 86) begin
        // end of segment, optionally followed by words to be skipped
        sl = 1'($urandom_range(0, 1));
        queue_word(header(OP_END, HdrAddrW'($urandom), SubW'($urandom), CountW'($urandom)),
                   sl);
        made++;
        if (!sl) begin
          repeat ($urandom_range(0, 6)) queue_word($urandom, 1'b0);
          queue_word($urandom, 1'b1);
        end
      end else if (kind < 93) begin
        queue_word('0, rand_last());
        made++;
      end else begin
        queue_word(header(op, HdrAddrW'($urandom), SubW'($urandom), '0), rand_last());
        made++;
      end
    end
  endtask

  task automatic run_phase(input bit program_limits, input logic [CfgDataW-1:0] host_val,
                           input logic [CfgDataW-1:0] eng_val);
    if (program_limits) begin
      write_reg(REG_HOST_LIMIT, host_val);
      write_reg(REG_ENGINE_LIMIT, eng_val);
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                CfgDataW'($urandom));
      gen_host   = int'(host_val[HostLimW-1:0]);
      gen_engine = int'(eng_val);
    end
    play_traffic(PhaseItems / 2);
    wait_drained(0);
    play_traffic(PhaseItems / 2);
    wait_drained(DrainCycles);
  endtask

  initial begin : stimulus
    logic [OpW-1:0] bad_op;
    logic [28:0]    tail;
    logic [CfgDataW-1:0] h;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_word('0, 1'b0);
    queue_word(header(OP_IMM, 12'd0, 3'd0, 13'd0), 1'b0);
    queue_word(32'h9FFF_FFFF, 1'b1);
    // burst crossing a segment boundary, zero word as data
    queue_word(header(OP_INC, 12'd63, 3'd2, 13'd3), 1'b0);
    queue_word('0, 1'b0);
    queue_word('1, 1'b1);
    queue_word(32'h1234_5678, 1'b0);
    queue_word(header(OP_NONINC, 12'd3583, 3'd5, 13'd2), 1'b0);
    queue_word($urandom, 1'b0);
    queue_word($urandom, 1'b0);
    queue_word(header(OP_ONEINC, 12'd3583, 3'd1, 13'd3), 1'b1);
    queue_word($urandom, 1'b0);
    queue_word($urandom, 1'b0);
    queue_word($urandom, 1'b1);
    queue_word(header(OP_INC, 12'd100, 3'd3, 13'd0), 1'b0);
    queue_word(header(OP_END, 12'd0, 3'd0, 13'd0), 1'b1);
    queue_word(header(OP_IMM, 12'd64, 3'd4, 13'h1234), 1'b0);
    // skipped words may hold anything, unsupported opcodes too
    queue_word(header(OP_END, 12'd5, 3'd0, 13'd0), 1'b0);
    queue_word({OP_RSVD0, 29'h1}, 1'b0);
    queue_word({OP_RSVD2, 29'h0}, 1'b0);
    queue_word({OP_RSVD6, 29'h1FFF_FFFF}, 1'b0);
    queue_word('1, 1'b1);
    queue_word(header(OP_IMM, 12'd3584, 3'd6, 13'd1), 1'b0);
    queue_word('1, 1'b1);
    queue_word(header(OP_IMM, 12'd4095, 3'd7, 13'h1FFF), 1'b1);
    wait_drained(DrainCycles);

    run_phase(1'b0, '0, '0);
    run_phase(1'b1, 13'd0, 13'd0);
    run_phase(1'b1, 13'h1FFF, 13'h1FFF);
    run_phase(1'b1, 13'd2000, 13'd100);
    run_phase(1'b1, 13'd0, 13'h1FFF);
    h = CfgDataW'($urandom_range(0, 4095));
    run_phase(1'b1, h, CfgDataW'($urandom_range(h, 8191)));
    run_phase(1'b1, CfgDataW'($urandom), CfgDataW'($urandom));

    // unsupported opcode, everything after it is dropped
    @(posedge clk_i);
    case ($urandom_range(0, 2))
      0:       bad_op = OP_RSVD0;
      1:       bad_op = OP_RSVD2;
      default: bad_op = OP_RSVD6;
    endcase
    tail = 29'($urandom);
    tail[0] = 1'b1;
    queue_word({bad_op, tail}, rand_last());
    repeat (20) queue_word($urandom, rand_last());
    wait_drained(DrainCycles);

    if (mismatches == 0 && expected_calls.size() == 0) begin
      $display("** pushbuffer_method_decoder: PASSED **");
    end else begin
      $display("** pushbuffer_method_decoder: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * 12);
    $display("** pushbuffer_method_decoder: FAILED **");
    $finish;
  end

endmodule

/* files.f */
src/pmd_pkg.sv
src/pmd_if.sv
src/pmd_decode.sv
src/pmd_route.sv
src/pushbuffer_method_decoder.sv
tb/pushbuffer_method_decoder_tb.sv
